### sv/bpa_pkg.sv
// Shared constants for the bitmap page allocator: field widths, request kinds,
// status codes and the page count reset value. No dependencies.
package bpa_pkg;

    localparam int KIND_W = 2;
    localparam int SIZE_W = 29;
    localparam int ADDR_W = 28;
    localparam int STAT_W = 2;
    localparam int CFG_W  = 17;

    localparam logic [CFG_W-1:0] PAGE_COUNT_RST = 17'd65536;

    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESERVE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK           = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_SPACE     = 2'd1;
    localparam logic [STAT_W-1:0] ST_OUT_OF_RANGE = 2'd2;

endpackage

### sv/bpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpa_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 8192,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/bpa_eval.sv
// Free-run evaluator for one map word: carries the running free-page count
// across the word and finds the lowest page that completes the run. No dependencies.
module bpa_eval #(
    parameter int PPW = 8,
    parameter int W   = 18
) (
    input  logic [PPW-1:0]         i_used,
    input  logic [W-1:0]           i_run,
    input  logic [W-1:0]           i_need,
    output logic                   o_hit,
    output logic [$clog2(PPW)-1:0] o_idx,
    output logic [W-1:0]           o_run
);

    localparam int CW = W + 1;
    localparam int IW = $clog2(PPW);

    logic [CW-1:0]  run_a [PPW];
    logic [PPW-1:0] hit;

    always_comb begin
        logic          seen;
        logic [CW-1:0] lastu;
        for (int i = 0; i < PPW; i++) begin
            seen  = 1'b0;
            lastu = '0;
            for (int j = 0; j <= i; j++) begin
                if (i_used[j]) begin
                    seen  = 1'b1;
                    lastu = CW'(j);
                end
            end
            if (seen) begin
                run_a[i] = CW'(i) - lastu;
            end else begin
                run_a[i] = CW'(i_run) + CW'(i + 1);
            end
            hit[i] = !i_used[i] && (run_a[i] >= CW'(i_need));
        end
    end

    always_comb begin
        o_idx = '0;
        for (int i = PPW - 1; i >= 0; i--) begin
            if (hit[i]) begin
                o_idx = IW'(i);
            end
        end
    end

    assign o_hit = |hit;
    assign o_run = W'(run_a[PPW-1]);

endmodule

### sv/bitmap_page_allocator_top.sv
// First-fit bitmap page allocator, top level: sequencer, page count and map RAM.
// Depends on bpa_pkg, bpa_ram and bpa_eval.
//
// After reset the map RAM is cleared one word a cycle, every map word in turn,
// with busy high; configuration writes are taken throughout. A request is
// taken when start is high and busy low, and its one result appears on
// o_done for a single cycle; the receiver cannot stall it, so sample it then.
// Zero-size, unknown-kind and out-of-range requests and allocs larger than
// the limit are answered straight from the decode state. An alloc scans one
// map word per cycle from page 0 until a fit is found or the limit is reached,
// then marks the run one word per cycle; free and reserve only mark. An
// alloc's scan and mark passes share the single RAM read and write port.
// busy stays high from acceptance until the result is presented.
module bitmap_page_allocator_top #(
    parameter int MAX_PAGES      = 65536,
    parameter int PAGE_BYTES     = 4096,
    parameter int PAGES_PER_WORD = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [bpa_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                         start,
    output logic                         busy,
    input  logic [bpa_pkg::KIND_W-1:0]   i_kind,
    input  logic [bpa_pkg::SIZE_W-1:0]   i_size_bytes,
    input  logic [bpa_pkg::ADDR_W-1:0]   i_base_address,
    output logic                         o_done,
    output logic [bpa_pkg::STAT_W-1:0]   o_status,
    output logic [bpa_pkg::ADDR_W-1:0]   o_region_address,
    output logic [bpa_pkg::CFG_W-1:0]    o_used_pages
);

    import bpa_pkg::*;

    localparam int PB_SH     = $clog2(PAGE_BYTES);
    localparam int PPW_SH    = $clog2(PAGES_PER_WORD);
    localparam int MAP_WORDS = (MAX_PAGES + PAGES_PER_WORD - 1) / PAGES_PER_WORD;
    localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int PAGE_W    = $clog2(MAX_PAGES + 1);
    localparam int NEED_W    = SIZE_W + 1 - PB_SH;
    localparam int BP_W      = ADDR_W - PB_SH;
    localparam int M1        = (BP_W > PAGE_W) ? BP_W : PAGE_W;
    localparam int M2        = (M1 > NEED_W) ? M1 : NEED_W;
    localparam int M3        = (M2 > CFG_W) ? M2 : CFG_W;
    localparam int E_W       = M3 + 1;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECODE = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_MARK   = 3'd4;

    logic [2:0]          r_state;
    logic [CFG_W-1:0]    r_page_count;
    logic [PAGE_W-1:0]   r_cnt;
    logic [KIND_W-1:0]   r_kind;
    logic [NEED_W-1:0]   r_need;
    logic [BP_W-1:0]     r_base_pg;
    logic [WA_W-1:0]     r_rd_word;
    logic [WA_W-1:0]     r_ev_word;
    logic                r_ev_valid;
    logic                r_issue;
    logic [E_W-1:0]      r_run;
    logic [E_W-1:0]      r_start;
    logic [E_W-1:0]      r_end;
    logic                r_done;
    logic [STAT_W-1:0]   r_status;
    logic [ADDR_W-1:0]   r_addr;

    logic [PAGE_W-1:0]         n_cnt;
    logic [SIZE_W:0]           w_size_rnd;
    logic [E_W-1:0]            w_lim;
    logic [E_W-1:0]            w_need;
    logic [E_W-1:0]            w_pg_base;
    logic [E_W-1:0]            w_range_end;
    logic [PAGES_PER_WORD-1:0] w_used;
    logic [PAGES_PER_WORD-1:0] w_mask;
    logic [PAGES_PER_WORD-1:0] w_rdata;
    logic [PAGES_PER_WORD-1:0] w_wdata;
    logic                      w_hit;
    logic [PPW_SH-1:0]         w_idx;
    logic [E_W-1:0]            w_run_out;
    logic [E_W-1:0]            w_hit_end;
    logic [E_W-1:0]            w_hit_start;
    logic                      w_scan_last;
    logic [WA_W-1:0]           w_mark_last;
    logic                      w_we;
    logic [WA_W-1:0]           w_waddr;
    logic [E_W-1:0]            w_cnt_sum;
    logic [E_W-1:0]            w_cnt_e;

    assign w_size_rnd  = {1'b0, i_size_bytes} + (SIZE_W + 1)'(PAGE_BYTES - 1);
    assign w_lim       = (E_W'(r_page_count) < E_W'(MAX_PAGES)) ?
                         E_W'(r_page_count) : E_W'(MAX_PAGES);
    assign w_need      = E_W'(r_need);
    assign w_pg_base   = E_W'({r_ev_word, {PPW_SH{1'b0}}});
    assign w_range_end = E_W'(r_base_pg) + w_need;
    assign w_hit_end   = w_pg_base + E_W'(w_idx) + E_W'(1);
    assign w_hit_start = w_hit_end - w_need;
    assign w_scan_last = (w_pg_base + E_W'(PAGES_PER_WORD)) >= w_lim;
    assign w_mark_last = WA_W'((r_end - E_W'(1)) >> PPW_SH);

    always_comb begin
        for (int i = 0; i < PAGES_PER_WORD; i++) begin
            w_used[i] = w_rdata[i] || ((w_pg_base + E_W'(i)) >= w_lim);
            w_mask[i] = ((w_pg_base + E_W'(i)) >= r_start) &&
                        ((w_pg_base + E_W'(i)) < r_end);
        end
    end

    assign w_wdata = (r_state == S_CLEAR) ? '0 :
                     (r_kind == KIND_FREE) ? (w_rdata & ~w_mask) : (w_rdata | w_mask);
    assign w_we    = (r_state == S_CLEAR) || ((r_state == S_MARK) && r_ev_valid);
    assign w_waddr = (r_state == S_CLEAR) ? r_rd_word : r_ev_word;

    assign w_cnt_e   = E_W'(r_cnt);
    assign w_cnt_sum = w_cnt_e + w_need;

    always_comb begin
        if (r_kind == KIND_FREE) begin
            n_cnt = (w_cnt_e > w_need) ? PAGE_W'(w_cnt_e - w_need) : '0;
        end else begin
            n_cnt = (w_cnt_sum > E_W'(MAX_PAGES)) ? PAGE_W'(MAX_PAGES) : PAGE_W'(w_cnt_sum);
        end
    end

    bpa_ram #(
        .W     (PAGES_PER_WORD),
        .DEPTH (MAP_WORDS),
        .AW    (WA_W)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_rd_word),
        .o_rdata (w_rdata)
    );

    bpa_eval #(
        .PPW (PAGES_PER_WORD),
        .W   (E_W)
    ) u_eval (
        .i_used (w_used),
        .i_run  (r_run),
        .i_need (w_need),
        .o_hit  (w_hit),
        .o_idx  (w_idx),
        .o_run  (w_run_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_page_count <= PAGE_COUNT_RST;
            r_cnt        <= '0;
            r_rd_word    <= '0;
            r_ev_valid   <= 1'b0;
            r_issue      <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_valid) begin
                r_page_count <= i_cfg_data;
            end
            case (r_state)
                S_CLEAR: begin
                    r_rd_word <= r_rd_word + WA_W'(1);
                    if (r_rd_word == WA_W'(MAP_WORDS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_kind    <= i_kind;
                        r_need    <= w_size_rnd[SIZE_W:PB_SH];
                        r_base_pg <= i_base_address[ADDR_W-1:PB_SH];
                        r_state   <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_ev_valid <= 1'b0;
                    r_issue    <= 1'b1;
                    r_run      <= '0;
                    if (r_kind == KIND_ALLOC && r_need != '0) begin
                        if (w_need > w_lim) begin
                            r_status <= ST_NO_SPACE;
                            r_addr   <= '0;
                            r_done   <= 1'b1;
                            r_state  <= S_IDLE;
                        end else begin
                            r_rd_word <= '0;
                            r_state   <= S_SCAN;
                        end
                    end else if ((r_kind == KIND_FREE || r_kind == KIND_RESERVE) &&
                                 r_need != '0) begin
                        if (w_range_end > w_lim) begin
                            r_status <= ST_OUT_OF_RANGE;
                            r_addr   <= '0;
                            r_done   <= 1'b1;
                            r_state  <= S_IDLE;
                        end else begin
                            r_start   <= E_W'(r_base_pg);
                            r_end     <= w_range_end;
                            r_rd_word <= WA_W'(E_W'(r_base_pg) >> PPW_SH);
                            r_state   <= S_MARK;
                        end
                    end else begin
                        r_status <= ST_OK;
                        r_addr   <= '0;
                        r_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    r_rd_word  <= r_rd_word + WA_W'(1);
                    r_ev_word  <= r_rd_word;
                    r_ev_valid <= 1'b1;
                    if (r_ev_valid) begin
                        if (w_hit) begin
                            r_start    <= w_hit_start;
                            r_end      <= w_hit_end;
                            r_rd_word  <= WA_W'(w_hit_start >> PPW_SH);
                            r_ev_valid <= 1'b0;
                            r_issue    <= 1'b1;
                            r_state    <= S_MARK;
                        end else if (w_scan_last) begin
                            r_status <= ST_NO_SPACE;
                            r_addr   <= '0;
                            r_done   <= 1'b1;
                            r_state  <= S_IDLE;
                        end else begin
                            r_run <= w_run_out;
                        end
                    end
                end
                S_MARK: begin
                    if (r_issue) begin
                        r_rd_word <= r_rd_word + WA_W'(1);
                        if (r_rd_word == w_mark_last) begin
                            r_issue <= 1'b0;
                        end
                    end
                    r_ev_valid <= r_issue;
                    r_ev_word  <= r_rd_word;
                    if (r_ev_valid && r_ev_word == w_mark_last) begin
                        r_cnt      <= n_cnt;
                        r_status   <= ST_OK;
                        r_addr     <= (r_kind == KIND_ALLOC) ?
                                      ADDR_W'({r_start, {PB_SH{1'b0}}}) : '0;
                        r_done     <= 1'b1;
                        r_ev_valid <= 1'b0;
                        r_issue    <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cfg_ready      = 1'b1;
    assign busy             = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_region_address = r_addr;
    assign o_used_pages     = CFG_W'(r_cnt);

endmodule
